// ===== hw/rtl/qrs_pkg.sv =====
package qrs_pkg;

  // Coefficient and result format, fixed by the payload fields
  localparam int unsigned CoefWidth = 32;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned BandWidth = 32;
  localparam logic [BandWidth-1:0] BandReset = 32'd4295;

  // Derived widths
  localparam int unsigned MagWidth  = CoefWidth;            // coefficient magnitude
  localparam int unsigned ProdWidth = 2 * MagWidth;         // b*b and a*c
  localparam int unsigned SqrtWidth = CoefWidth + 1;        // root of the discriminant
  localparam int unsigned DiscWidth = 2 * SqrtWidth;        // discriminant magnitude
  localparam int unsigned NumWidth  = SqrtWidth + 1;        // -b +/- sqrt(d) magnitude
  localparam int unsigned DvdWidth  = NumWidth + FracBits;  // scaled dividend

  typedef enum logic [1:0] {
    KIND_DOUBLE  = 2'd0,
    KIND_TWO     = 2'd1,
    KIND_COMPLEX = 2'd2,
    KIND_AZERO   = 2'd3
  } qrs_kind_e;

  // Input word
  typedef struct packed {
    logic signed [CoefWidth-1:0] coef_a;
    logic signed [CoefWidth-1:0] coef_b;
    logic signed [CoefWidth-1:0] coef_c;
  } qrs_in_t;

  // Output word
  typedef struct packed {
    logic [1:0]                  root_kind;
    logic signed [CoefWidth-1:0] first_real;
    logic signed [CoefWidth-1:0] second_real;
    logic signed [CoefWidth-1:0] imag_part;
    logic                        saturated;
  } qrs_out_t;

  // Classified job without the discriminant
  typedef struct packed {
    qrs_kind_e             kind;
    logic                  a_neg;
    logic                  nb_neg;   // sign of -b
    logic [MagWidth-1:0]   a_mag;
    logic [MagWidth-1:0]   b_mag;
  } qrs_ctl_t;

  // Queue entry between front and back
  typedef struct packed {
    qrs_ctl_t              ctl;
    logic [DiscWidth-1:0]  d_mag;
  } qrs_job_t;

  // Sideband that rides along the dividers
  typedef struct packed {
    qrs_kind_e kind;
    logic      neg1;
    logic      neg2;
  } qrs_meta_t;

endpackage

// ===== hw/rtl/qrs_front.sv =====
module qrs_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  qrs_pkg::qrs_in_t                 in_data_i,
  input  logic                             cfg_we_i,
  input  logic [qrs_pkg::BandWidth-1:0]    cfg_wdata_i,
  input  logic                             q_full_i,
  output logic                             push_o,
  output qrs_pkg::qrs_job_t                job_o
);

  localparam int unsigned MW = qrs_pkg::MagWidth;
  localparam int unsigned PW = qrs_pkg::ProdWidth;
  localparam int unsigned DW = qrs_pkg::DiscWidth;
  localparam int unsigned CW = qrs_pkg::CoefWidth;

  logic [3:0] v_q;
  logic       en;

  logic [qrs_pkg::BandWidth-1:0] band_q;

  // stage 1: signs and magnitudes
  logic [MW-1:0] ua, ub, uc;
  logic [MW-1:0] a_mag_d, b_mag_d, c_mag_d;
  logic [MW-1:0] a1_q, b1_q, c1_q;
  logic          sa1_q, sb1_q, sc1_q;

  // stage 2: products
  logic [PW-1:0] b2_q, ac_q;
  logic [MW-1:0] a2_q, b2m_q;
  logic          sa2_q, sb2_q, sc2_q, az2_q;

  // stage 3: discriminant
  logic [DW-1:0] b2e, ac4, d_d, d3_q;
  logic          dneg_d, dneg3_q;
  logic [MW-1:0] a3_q, b3_q;
  logic          sa3_q, sb3_q, az3_q;

  // stage 4: classified job
  qrs_pkg::qrs_job_t job_q;
  qrs_pkg::qrs_kind_e kind_d;

  // all stages move together; only a full queue holds them
  assign en         = !v_q[3] || !q_full_i;
  assign in_stall_o = !en;
  assign push_o     = v_q[3] && !q_full_i;
  assign job_o      = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[2:0], in_valid_i};
    end
  end

  // band register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_q <= qrs_pkg::BandReset;
    end else if (cfg_we_i) begin
      band_q <= cfg_wdata_i;
    end
  end

  assign ua = in_data_i.coef_a;
  assign ub = in_data_i.coef_b;
  assign uc = in_data_i.coef_c;
  assign a_mag_d = ua[CW-1] ? (~ua + 1'b1) : ua;
  assign b_mag_d = ub[CW-1] ? (~ub + 1'b1) : ub;
  assign c_mag_d = uc[CW-1] ? (~uc + 1'b1) : uc;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_q  <= a_mag_d;
      b1_q  <= b_mag_d;
      c1_q  <= c_mag_d;
      sa1_q <= ua[CW-1];
      sb1_q <= ub[CW-1];
      sc1_q <= uc[CW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b2_q  <= PW'(b1_q) * PW'(b1_q);
      ac_q  <= PW'(a1_q) * PW'(c1_q);
      a2_q  <= a1_q;
      b2m_q <= b1_q;
      sa2_q <= sa1_q;
      sb2_q <= sb1_q;
      sc2_q <= sc1_q;
      az2_q <= (a1_q == '0);
    end
  end

  // d = b*b - 4ac as sign and magnitude
  assign b2e = DW'(b2_q);
  assign ac4 = DW'({ac_q, 2'b00});

  always_comb begin
    dneg_d = 1'b0;
    if (sa2_q ^ sc2_q) begin
      d_d = b2e + ac4;
    end else if (b2e < ac4) begin
      d_d    = ac4 - b2e;
      dneg_d = 1'b1;
    end else begin
      d_d = b2e - ac4;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d3_q    <= d_d;
      dneg3_q <= dneg_d;
      a3_q    <= a2_q;
      b3_q    <= b2m_q;
      sa3_q   <= sa2_q;
      sb3_q   <= sb2_q;
      az3_q   <= az2_q;
    end
  end

  // classify against the zero band
  always_comb begin
    if (az3_q) begin
      kind_d = qrs_pkg::KIND_AZERO;
    end else if (d3_q < DW'(band_q)) begin
      kind_d = qrs_pkg::KIND_DOUBLE;
    end else if (dneg3_q) begin
      kind_d = qrs_pkg::KIND_COMPLEX;
    end else begin
      kind_d = qrs_pkg::KIND_TWO;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      job_q.ctl.kind   <= kind_d;
      job_q.ctl.a_neg  <= sa3_q;
      job_q.ctl.nb_neg <= !sb3_q;
      job_q.ctl.a_mag  <= a3_q;
      job_q.ctl.b_mag  <= b3_q;
      job_q.d_mag      <= d3_q;
    end
  end

endmodule

// ===== hw/rtl/qrs_fifo.sv =====
module qrs_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  qrs_pkg::qrs_job_t data_i,
  input  logic              pop_i,
  output qrs_pkg::qrs_job_t data_o,
  output logic              full_o,
  output logic              empty_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  qrs_pkg::qrs_job_t mem_q [Depth];
  logic [AW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // pointers wrap at Depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/qrs_sqrt.sv =====
module qrs_sqrt (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [qrs_pkg::DiscWidth-1:0]   rad_i,
  output logic [qrs_pkg::SqrtWidth-1:0]   root_o
);

  localparam int unsigned SW = qrs_pkg::SqrtWidth;
  localparam int unsigned DW = qrs_pkg::DiscWidth;
  localparam int unsigned RW = SW + 3;

  // index k holds the state entering stage k
  logic [RW-1:0] rem_q  [SW];
  logic [SW-1:0] root_q [SW+1];
  logic [DW-1:0] rad_q  [SW];

  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign rad_q[0]  = rad_i;
  assign root_o    = root_q[SW];

  // one root bit per stage, two radicand bits in
  for (genvar k = 0; k < SW; k++) begin : g_stage
    logic [RW-1:0] rem_n, trial;
    logic          ge;

    assign rem_n = {rem_q[k][RW-3:0], rad_q[k][DW-1 -: 2]};
    assign trial = RW'({root_q[k], 2'b01});
    assign ge    = (rem_n >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k+1] <= {root_q[k][SW-2:0], ge};
      end
    end

    if (k + 1 < SW) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k+1] <= ge ? (rem_n - trial) : rem_n;
          rad_q[k+1] <= {rad_q[k][DW-3:0], 2'b00};
        end
      end
    end
  end

endmodule

// ===== hw/rtl/qrs_div.sv =====
module qrs_div (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [qrs_pkg::DvdWidth-1:0]   num_i,
  input  logic [qrs_pkg::MagWidth-1:0]   den_i,
  output logic [qrs_pkg::DvdWidth-1:0]   quo_o
);

  localparam int unsigned QW = qrs_pkg::DvdWidth;
  localparam int unsigned MW = qrs_pkg::MagWidth;

  // nq holds the unread dividend bits on top and the quotient bits below
  logic [MW-1:0] rem_q [QW];
  logic [QW-1:0] nq_q  [QW+1];
  logic [MW-1:0] den_q [QW];

  assign rem_q[0] = '0;
  assign nq_q[0]  = num_i;
  assign den_q[0] = den_i;
  assign quo_o    = nq_q[QW];

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [MW:0] rem_n, diff;
    logic        ge;

    assign rem_n = {rem_q[k], nq_q[k][QW-1]};
    assign diff  = rem_n - {1'b0, den_q[k]};
    assign ge    = (rem_n >= {1'b0, den_q[k]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q[k+1] <= {nq_q[k][QW-2:0], ge};
      end
    end

    if (k + 1 < QW) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k+1] <= ge ? diff[MW-1:0] : rem_n[MW-1:0];
          den_q[k+1] <= den_q[k];
        end
      end
    end
  end

endmodule

// ===== hw/rtl/qrs_back.sv =====
module qrs_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  qrs_pkg::qrs_job_t job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output qrs_pkg::qrs_out_t out_data_o
);

  localparam int unsigned SW = qrs_pkg::SqrtWidth;
  localparam int unsigned QW = qrs_pkg::DvdWidth;
  localparam int unsigned NW = qrs_pkg::NumWidth;
  localparam int unsigned CW = qrs_pkg::CoefWidth;
  localparam int unsigned MW = qrs_pkg::MagWidth;
  localparam int unsigned FB = qrs_pkg::FracBits;
  localparam int unsigned L  = SW + QW + 2;

  localparam logic [QW-1:0] PosLim = {{(QW - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
  localparam logic [QW-1:0] NegLim = PosLim + 1'b1;

  logic          en;
  logic [L-1:0]  vb_q;

  qrs_pkg::qrs_ctl_t  ctl_q [SW];
  logic [SW-1:0]      root;

  logic [NW-1:0]      n1_d, n2_d, n1_q, n2_q, ni_q;
  logic               s1_d, s2_d;
  logic [NW-1:0]      mb_e, s_e;
  logic [MW-1:0]      a_q;
  qrs_pkg::qrs_meta_t meta_d, meta_q;
  qrs_pkg::qrs_meta_t md_q [QW];

  logic [QW-1:0]      q1, q2, qi;
  logic [CW:0]        f1, f2, fi;
  qrs_pkg::qrs_out_t  out_d, out_q;

  // scale quotient by one half, clip to the coefficient range, apply sign
  function automatic logic [CW:0] fix_q(input logic [QW-1:0] q, input logic neg);
    logic [QW-1:0] qh, lim, mag;
    logic          ng, sat;
    logic [CW-1:0] val;
    qh  = q >> 1;
    ng  = neg && (qh != '0);
    lim = ng ? NegLim : PosLim;
    sat = (qh > lim);
    mag = sat ? lim : qh;
    val = ng ? (~mag[CW-1:0] + 1'b1) : mag[CW-1:0];
    return {sat, val};
  endfunction

  // whole back end moves whenever the output slot frees
  assign en          = !vb_q[L-1] || !out_stall_i;
  assign pop_o       = en && !empty_i;
  assign out_valid_o = vb_q[L-1];
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= '0;
    end else if (en) begin
      vb_q <= {vb_q[L-2:0], !empty_i};
    end
  end

  // square root, control word follows alongside
  qrs_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (job_i.d_mag),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctl_q[0] <= job_i.ctl;
      for (int k = 1; k < SW; k++) begin
        ctl_q[k] <= ctl_q[k-1];
      end
    end
  end

  // numerators in sign and magnitude: -b + s and -b - s for two real roots, -b otherwise
  assign mb_e = NW'(ctl_q[SW-1].b_mag);
  assign s_e  = NW'(root);

  always_comb begin
    if (ctl_q[SW-1].kind == qrs_pkg::KIND_TWO) begin
      if (!ctl_q[SW-1].nb_neg) begin
        n1_d = mb_e + s_e;
        s1_d = 1'b0;
        if (mb_e >= s_e) begin
          n2_d = mb_e - s_e;
          s2_d = 1'b0;
        end else begin
          n2_d = s_e - mb_e;
          s2_d = 1'b1;
        end
      end else begin
        n2_d = mb_e + s_e;
        s2_d = 1'b1;
        if (mb_e >= s_e) begin
          n1_d = mb_e - s_e;
          s1_d = 1'b1;
        end else begin
          n1_d = s_e - mb_e;
          s1_d = 1'b0;
        end
      end
    end else begin
      n1_d = mb_e;
      n2_d = mb_e;
      s1_d = ctl_q[SW-1].nb_neg;
      s2_d = ctl_q[SW-1].nb_neg;
    end
    meta_d.kind = ctl_q[SW-1].kind;
    meta_d.neg1 = s1_d ^ ctl_q[SW-1].a_neg;
    meta_d.neg2 = s2_d ^ ctl_q[SW-1].a_neg;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n1_q   <= n1_d;
      n2_q   <= n2_d;
      ni_q   <= s_e;
      a_q    <= ctl_q[SW-1].a_mag;
      meta_q <= meta_d;
    end
  end

  // three dividers by |a|, each dividend scaled by the fraction bits
  qrs_div u_div1 (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({n1_q, {FB{1'b0}}}),
    .den_i (a_q),
    .quo_o (q1)
  );

  qrs_div u_div2 (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({n2_q, {FB{1'b0}}}),
    .den_i (a_q),
    .quo_o (q2)
  );

  qrs_div u_divi (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({ni_q, {FB{1'b0}}}),
    .den_i (a_q),
    .quo_o (qi)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      md_q[0] <= meta_q;
      for (int k = 1; k < QW; k++) begin
        md_q[k] <= md_q[k-1];
      end
    end
  end

  // final clip and output word
  assign f1 = fix_q(q1, md_q[QW-1].neg1);
  assign f2 = fix_q(q2, md_q[QW-1].neg2);
  assign fi = fix_q(qi, 1'b0);

  always_comb begin
    out_d.root_kind = md_q[QW-1].kind;
    case (md_q[QW-1].kind)
      qrs_pkg::KIND_DOUBLE: begin
        out_d.first_real  = f1[CW-1:0];
        out_d.second_real = f1[CW-1:0];
        out_d.imag_part   = '0;
        out_d.saturated   = f1[CW];
      end
      qrs_pkg::KIND_TWO: begin
        out_d.first_real  = f1[CW-1:0];
        out_d.second_real = f2[CW-1:0];
        out_d.imag_part   = '0;
        out_d.saturated   = f1[CW] | f2[CW];
      end
      qrs_pkg::KIND_COMPLEX: begin
        out_d.first_real  = f1[CW-1:0];
        out_d.second_real = f1[CW-1:0];
        out_d.imag_part   = fi[CW-1:0];
        out_d.saturated   = f1[CW] | fi[CW];
      end
      default: begin
        out_d.first_real  = '0;
        out_d.second_real = '0;
        out_d.imag_part   = '0;
        out_d.saturated   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

endmodule

// ===== hw/rtl/quadratic_root_solver_unit.sv =====
// Quadratic root solver: takes a, b, c as signed Q16.16 and returns the root
// kind (double, two real, complex pair, or a equal to zero) with the roots in
// Q16.16, truncated toward zero, clipped to range with the saturated flag set.
// The zero band register (reset 4295, Q32.32 LSBs) sets how close to zero
// the discriminant must be to count as a double root. One word is taken and
// one delivered per clock when neither side stalls. A word passes through
// 4 front stages (magnitudes, products, discriminant, classification), the
// queue, the 33-stage bit-per-stage square root, a numerator stage, the
// 50-stage bit-per-stage divider and the output register. A queue
// of QueueDepth words sits between the front and the back so each side stalls
// on its own.
module quadratic_root_solver_unit #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  qrs_pkg::qrs_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output qrs_pkg::qrs_out_t             out_data_o,
  input  logic                          cfg_we_i,
  input  logic [qrs_pkg::BandWidth-1:0] cfg_wdata_i
);

  logic              push, pop, full, empty;
  qrs_pkg::qrs_job_t job_in, job_out;

  // front: magnitudes, discriminant, classification
  qrs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_full_i    (full),
    .push_o      (push),
    .job_o       (job_in)
  );

  // job queue
  qrs_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .pop_i   (pop),
    .data_o  (job_out),
    .full_o  (full),
    .empty_o (empty)
  );

  // back: square root, division, clipping
  qrs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
